>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked property, disabled while reset is asserted (active low)
`define SPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked property that also holds during reset
`define SPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// sizes, codes and types shared by the sparse polynomial multiplier
// ----------------------------------------------------------------------------
package spm_pkg;

    // store and field sizes
    localparam int MAX_TERMS     = 8;
    localparam int COEF_BITS     = 16;
    localparam int EXP_BITS      = 8;
    localparam int OUT_COEF_BITS = 38;
    localparam int OUT_EXP_BITS  = 9;

    // derived sizes
    localparam int NUM_CELLS  = MAX_TERMS * MAX_TERMS;
    localparam int PEXP_BITS  = EXP_BITS + 1;
    localparam int IDX_BITS   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_TERMS + 1);
    localparam int FLUSH_CYC  = NUM_CELLS + 4;
    localparam int FLUSH_BITS = $clog2(FLUSH_CYC + 1);

    // request codes
    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_MUL    = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_FLUSH,
        ST_DRAIN,
        ST_ZERO
    } t_state;

    // one product term, either in flight or held by a cell
    typedef struct packed {
        logic                            vld;
        logic signed [OUT_COEF_BITS-1:0] coef;
        logic        [PEXP_BITS-1:0]     pexp;
    } t_term;

endpackage

>>> src/spm_cell.sv
// ----------------------------------------------------------------------------
// spm_cell
// one accumulation cell: claims a product exponent, folds in matching
// terms and hands other terms on to its right neighbor
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spm_cell
    import spm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clr,
    input  logic  i_shift,
    input  t_term i_tok,
    input  t_term i_next,
    output t_term o_tok,
    output t_term o_entry
);

    t_term r_ent, n_ent;
    t_term r_tok, n_tok;

    // clear, absorb, claim, pass on, or shift toward the output end
    always_comb begin
        n_ent     = r_ent;
        n_tok     = i_tok;
        n_tok.vld = 1'b0;
        if (i_clr) begin
            n_ent.vld = 1'b0;
        end else if (i_shift) begin
            n_ent = i_next;
        end else if (i_tok.vld) begin
            if (!r_ent.vld) begin
                n_ent = i_tok;
            end else if (r_ent.pexp == i_tok.pexp) begin
                n_ent.coef = r_ent.coef + i_tok.coef;
            end else begin
                n_tok = i_tok;
            end
        end
    end

    // state registers, only valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_ent <= n_ent;
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_entry = r_ent;

    // checks
    `SPM_ASSERT(a_clr_empties, i_clk, i_rst_n, i_clr |=> !r_ent.vld && !r_tok.vld, "cell not cleared")
    `SPM_ASSERT(a_claim, i_clk, i_rst_n, i_tok.vld && !r_ent.vld && !i_clr && !i_shift |=> r_ent.vld && !r_tok.vld, "empty cell did not claim term")
    `SPM_ASSERT(a_fold, i_clk, i_rst_n, i_tok.vld && r_ent.vld && (r_ent.pexp == i_tok.pexp) && !i_clr && !i_shift |=> !r_tok.vld && (r_ent.coef == $past(r_ent.coef + i_tok.coef)), "matching term not folded")

endmodule

>>> src/sparse_polynomial_multiply_unit.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply_unit
// term stores for two sparse polynomials and a chain of accumulation cells
// that combines their product terms by exponent in first-occurrence order
// ----------------------------------------------------------------------------
// channel   direction  transfer
// request   in         start && !busy: i_req_type, i_term_coef, i_term_exp
// result    out        o_strobe: o_out_coef, o_out_exp, o_zero_poly, o_last_term
//
// loads and clears leave busy low.
// a multiply with an empty store gives its single result from ST_ZERO via the result register.
// otherwise: ST_GEN issues all a_count*b_count products into the cell chain, one per
// cycle through the multiplier, then ST_FLUSH lets the last term settle,
// then the cells shift out one result per cycle.
// synchronous active-low reset clears counts, valid bits and the sequencer.
// the receiver cannot stall; results are shown for one cycle each.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_polynomial_multiply_unit
    import spm_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_req_type,
    input  logic signed [15:0]              i_term_coef,
    input  logic [7:0]                      i_term_exp,
    output logic                            o_strobe,
    output logic signed [OUT_COEF_BITS-1:0] o_out_coef,
    output logic [OUT_EXP_BITS-1:0]         o_out_exp,
    output logic                            o_zero_poly,
    output logic                            o_last_term
);

    // term stores
    logic signed [COEF_BITS-1:0] r_a_coef [MAX_TERMS];
    logic        [EXP_BITS-1:0]  r_a_exp  [MAX_TERMS];
    logic signed [COEF_BITS-1:0] r_b_coef [MAX_TERMS];
    logic        [EXP_BITS-1:0]  r_b_exp  [MAX_TERMS];
    logic        [CNT_BITS-1:0]  r_a_count, r_b_count;

    // sequencer
    t_state                r_state, n_state;
    logic [IDX_BITS-1:0]   r_i, r_j;
    logic [FLUSH_BITS-1:0] r_flush_cnt;

    // product pipeline
    logic                        r_op_vld;
    logic signed [COEF_BITS-1:0] r_op_a, r_op_b;
    logic [PEXP_BITS-1:0]        r_op_exp;
    logic signed [2*COEF_BITS-1:0] w_prod;
    t_term                       r_tok;

    // output registers
    logic                            r_strobe;
    logic signed [OUT_COEF_BITS-1:0] r_out_coef;
    logic [OUT_EXP_BITS-1:0]         r_out_exp;
    logic                            r_zero, r_last;

    // chain wiring
    t_term w_tok [NUM_CELLS+1];
    t_term w_ent [NUM_CELLS+1];

    logic w_accept, w_mul, w_empty, w_j_last, w_i_last, w_flush_done;
    logic w_gen, w_shift, w_clr;
    logic signed [COEF_BITS-1:0] w_in_coef;
    logic [EXP_BITS-1:0]         w_in_exp;

    // request decode
    assign w_accept  = start && !busy;
    assign w_mul     = w_accept && (t_req'(i_req_type) == REQ_MUL);
    assign w_empty   = (r_a_count == '0) || (r_b_count == '0);
    assign w_in_coef = COEF_BITS'($unsigned(i_term_coef));
    assign w_in_exp  = EXP_BITS'(i_term_exp);
    assign w_j_last  = (CNT_BITS'(r_j) + CNT_BITS'(1)) == r_b_count;
    assign w_i_last  = (CNT_BITS'(r_i) + CNT_BITS'(1)) == r_a_count;
    assign w_flush_done = r_flush_cnt == FLUSH_BITS'(FLUSH_CYC - 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_mul) begin
                    n_state = w_empty ? ST_ZERO : ST_GEN;
                end
            end
            ST_GEN: begin
                if (w_i_last && w_j_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_flush_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_ent[1].vld) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ZERO: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy    = 1'b1;
        w_gen   = 1'b0;
        w_shift = 1'b0;
        case (r_state)
            ST_IDLE:  busy    = 1'b0;
            ST_GEN:   w_gen   = 1'b1;
            ST_FLUSH: busy    = 1'b1;
            ST_DRAIN: w_shift = 1'b1;
            ST_ZERO:  busy    = 1'b1;
            default:  busy    = 1'b1;
        endcase
    end

    assign w_clr = w_mul;

    // sequencer, counts and index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_a_count   <= '0;
            r_b_count   <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_flush_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                case (t_req'(i_req_type))
                    REQ_LOAD_A: begin
                        if (r_a_count < CNT_BITS'(MAX_TERMS)) begin
                            r_a_count <= r_a_count + CNT_BITS'(1);
                        end
                    end
                    REQ_LOAD_B: begin
                        if (r_b_count < CNT_BITS'(MAX_TERMS)) begin
                            r_b_count <= r_b_count + CNT_BITS'(1);
                        end
                    end
                    REQ_CLEAR: begin
                        r_a_count <= '0;
                        r_b_count <= '0;
                    end
                    default: begin
                        r_i         <= '0;
                        r_j         <= '0;
                        r_flush_cnt <= '0;
                    end
                endcase
            end
            // walk b inner, a outer
            if (w_gen) begin
                if (w_j_last) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_BITS'(1);
                end else begin
                    r_j <= r_j + IDX_BITS'(1);
                end
            end
            if (r_state == ST_FLUSH) begin
                r_flush_cnt <= r_flush_cnt + FLUSH_BITS'(1);
            end
        end
    end

    // store writes, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept && (t_req'(i_req_type) == REQ_LOAD_A)
                && (r_a_count < CNT_BITS'(MAX_TERMS))) begin
            r_a_coef[IDX_BITS'(r_a_count)] <= w_in_coef;
            r_a_exp[IDX_BITS'(r_a_count)]  <= w_in_exp;
        end
        if (w_accept && (t_req'(i_req_type) == REQ_LOAD_B)
                && (r_b_count < CNT_BITS'(MAX_TERMS))) begin
            r_b_coef[IDX_BITS'(r_b_count)] <= w_in_coef;
            r_b_exp[IDX_BITS'(r_b_count)]  <= w_in_exp;
        end
    end

    // operand fetch, multiply, token into the chain
    assign w_prod = r_op_a * r_op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_vld  <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_op_vld  <= w_gen;
            r_tok.vld <= r_op_vld && !w_clr;
        end
        r_op_a     <= r_a_coef[r_i];
        r_op_b     <= r_b_coef[r_j];
        r_op_exp   <= PEXP_BITS'(r_a_exp[r_i]) + PEXP_BITS'(r_b_exp[r_j]);
        r_tok.coef <= OUT_COEF_BITS'(w_prod);
        r_tok.pexp <= r_op_exp;
    end

    // accumulation chain
    assign w_tok[0]         = r_tok;
    assign w_ent[NUM_CELLS] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        spm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (w_clr),
            .i_shift (w_shift),
            .i_tok   (w_tok[k]),
            .i_next  (w_ent[k+1]),
            .o_tok   (w_tok[k+1]),
            .o_entry (w_ent[k])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (w_shift && w_ent[0].vld) || (r_state == ST_ZERO);
        end
        if (r_state == ST_ZERO) begin
            r_out_coef <= '0;
            r_out_exp  <= '0;
            r_zero     <= 1'b1;
            r_last     <= 1'b1;
        end else begin
            r_out_coef <= w_ent[0].coef;
            r_out_exp  <= OUT_EXP_BITS'(w_ent[0].pexp);
            r_zero     <= 1'b0;
            r_last     <= !w_ent[1].vld;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_coef  = r_out_coef;
    assign o_out_exp   = r_out_exp;
    assign o_zero_poly = r_zero;
    assign o_last_term = r_last;

    // checks
    `SPM_ASSERT(a_zero_result, i_clk, i_rst_n, o_strobe && o_zero_poly |-> o_last_term && (o_out_coef == '0) && (o_out_exp == '0), "bad zero-polynomial result")
    `SPM_ASSERT(a_chain_end, i_clk, i_rst_n, !w_tok[NUM_CELLS].vld, "product term fell off the cell chain")
    `SPM_ASSERT(a_mul_busy, i_clk, i_rst_n, w_mul |=> busy, "multiply did not raise busy")
    `SPM_ASSERT(a_drain_nonempty, i_clk, i_rst_n, (r_state == ST_FLUSH) && w_flush_done |=> w_ent[0].vld, "no product term at drain start")

endmodule
